### rtl/c8ie_pkg.sv
// ============================================================================
// c8ie_pkg
// Shared types and constants for the CHIP-8 instruction executor.
// ============================================================================
package c8ie_pkg;

    typedef enum logic [3:0] {
        EV_DONE     = 4'd0,
        EV_MEMWRITE = 4'd1,
        EV_CLEAR    = 4'd2,
        EV_SETDLY   = 4'd3,
        EV_SETSND   = 4'd4,
        EV_WAITKEY  = 4'd5,
        EV_UNSUP    = 4'd6,
        EV_UNDER    = 4'd7,
        EV_OVER     = 4'd8
    } t_event;

    // ALU operations of the shared unit
    typedef enum logic [3:0] {
        ALU_PASSB, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUBXY, ALU_SUBYX,
        ALU_SHR, ALU_SHL, ALU_EQ
    } t_alu_op;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
        logic       eq;
    } t_alu_out;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_BCD, ST_STORE, ST_EMIT
    } t_state;

    localparam logic [11:0] PC_RESET   = 12'd512;
    localparam logic [11:0] FONT_RESET = 12'd80;

endpackage

### rtl/c8ie_alu.sv
// ============================================================================
// c8ie_alu
// Shared 8-bit arithmetic, logic, shift and compare unit.
// ============================================================================
module c8ie_alu (
    input  logic [7:0]        i_a,
    input  logic [7:0]        i_b,
    input  c8ie_pkg::t_alu_op i_op,
    output c8ie_pkg::t_alu_out o_res
);
    import c8ie_pkg::*;
    logic [8:0] w_sum;
    logic [8:0] w_dxy;
    logic [8:0] w_dyx;

    assign w_sum = {1'b0, i_a} + {1'b0, i_b};
    assign w_dxy = {1'b0, i_a} - {1'b0, i_b};
    assign w_dyx = {1'b0, i_b} - {1'b0, i_a};

    always_comb begin
        o_res.res  = i_b;
        o_res.flag = 1'b0;
        o_res.eq   = (i_a == i_b);
        case (i_op)
            ALU_PASSB: o_res.res = i_b;
            ALU_OR:    o_res.res = i_a | i_b;
            ALU_AND:   o_res.res = i_a & i_b;
            ALU_XOR:   o_res.res = i_a ^ i_b;
            ALU_ADD: begin
                o_res.res = w_sum[7:0]; o_res.flag = w_sum[8];
            end
            ALU_SUBXY: begin
                o_res.res = w_dxy[7:0]; o_res.flag = ~w_dxy[8];
            end
            ALU_SUBYX: begin
                o_res.res = w_dyx[7:0]; o_res.flag = ~w_dyx[8];
            end
            ALU_SHR: begin
                o_res.res = {1'b0, i_a[7:1]}; o_res.flag = i_a[0];
            end
            ALU_SHL: begin
                o_res.res = {i_a[6:0], 1'b0}; o_res.flag = i_a[7];
            end
            default: o_res.res = i_b;
        endcase
    end
endmodule

### rtl/chip8_instruction_executor_unit.sv
// ============================================================================
// chip8_instruction_executor_unit
// Executes one CHIP-8 instruction per request and emits its side effects.
// ============================================================================
// Channel   | Dir | Payload
// s_axis    | in  | tdata = opcode_word[15:0], key_mask[31:16], random_byte[39:32],
//           |     |         delay_now[47:40]
// m_axis    | out | tdata = event_res[3:0], mem_addr[19:4], out_data[27:20],
//           |     |         pc_now[39:28]; tlast = last_of_run
// cfg       | in  | i_cfg_data = font_base (12 bit)
//
// Most requests are accepted in idle, executed through the shared ALU in the
// execute state, and their result held in the result register in the emit
// state. Fx33 runs a digit loop on the shared ALU: one step per subtraction
// of 100 or 10 plus one closing step per digit, and an emit state for each
// of its three writes. Fx55 passes through a store state and an emit state
// for each write after the first while the sink accepts. A stalled sink
// holds the result register.
// Reset (synchronous, active low) sets PC to 512, I and V0..VF to zero,
// stack level to zero and font_base to 80. The return stack needs no reset.
// ============================================================================
module chip8_instruction_executor_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // opcode, key_mask, random_byte, delay_now
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // event_res, mem_addr, out_data, pc_now
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data
);
    import c8ie_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);

    t_state r_state, n_state;
    logic [7:0]  r_v [16];
    logic [11:0] r_pc, r_font;
    logic [15:0] r_i;
    logic [SP_W-1:0] r_sp;
    logic [11:0] r_stk [STACK_DEPTH];
    logic [15:0] r_op, r_keys;
    logic [7:0]  r_rnd, r_dly;
    logic [3:0]  r_cnt;     // BCD step / store index
    logic [7:0]  r_rem;     // BCD remainder
    logic [3:0]  r_dig;     // BCD digit in progress
    // result register
    logic [3:0]  r_ev;
    logic [15:0] r_addr;
    logic [7:0]  r_data;
    logic        r_last;

    logic [3:0] w_hi, w_x, w_y, w_n;
    logic [7:0] w_kk, w_vx, w_vy;
    logic [11:0] w_nnn, w_pcf;
    t_alu_op  w_aop;
    logic [7:0] w_a, w_b;
    t_alu_out w_alu;
    logic [7:0] w_bcd_k;
    logic w_fire, w_take;

    assign w_hi  = r_op[15:12];
    assign w_x   = r_op[11:8];
    assign w_y   = r_op[7:4];
    assign w_n   = r_op[3:0];
    assign w_kk  = r_op[7:0];
    assign w_nnn = r_op[11:0];
    assign w_vx  = r_v[w_x];
    assign w_vy  = r_v[w_y];
    assign w_pcf = r_pc + 12'd2;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = {r_pc, r_data, r_addr, r_ev};
    assign m_axis_tlast  = r_last;
    assign w_fire = m_axis_tvalid && m_axis_tready;
    assign w_take = s_axis_tvalid && s_axis_tready;

    assign w_bcd_k = (r_cnt == 4'd0) ? 8'd100 : 8'd10;

    // Select operands and operation of the shared unit
    always_comb begin
        w_a = w_vx; w_b = w_vy; w_aop = ALU_EQ;
        if (r_state == ST_BCD) begin
            w_a = r_rem; w_b = w_bcd_k; w_aop = ALU_SUBXY;
        end else begin
            case (w_hi)
                4'h3, 4'h4: w_b = w_kk;
                4'h7: begin w_b = w_kk; w_aop = ALU_ADD; end
                4'h8: begin
                    case (w_n)
                        4'h0: w_aop = ALU_PASSB;
                        4'h1: w_aop = ALU_OR;
                        4'h2: w_aop = ALU_AND;
                        4'h3: w_aop = ALU_XOR;
                        4'h4: w_aop = ALU_ADD;
                        4'h5: w_aop = ALU_SUBXY;
                        4'h6: w_aop = ALU_SHR;
                        4'h7: w_aop = ALU_SUBYX;
                        4'hE: w_aop = ALU_SHL;
                        default: w_aop = ALU_EQ;
                    endcase
                end
                4'hC: begin w_a = w_kk; w_b = r_rnd; w_aop = ALU_AND; end
                default: w_aop = ALU_EQ;
            endcase
        end
    end

    c8ie_alu u_alu (.i_a(w_a), .i_b(w_b), .i_op(w_aop), .o_res(w_alu));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_take) n_state = ST_EXEC;
            ST_EXEC: begin
                n_state = ST_EMIT;
                if (w_hi == 4'hF && w_kk == 8'h33) n_state = ST_BCD;
            end
            ST_BCD:   if (w_alu.flag == 1'b0) n_state = ST_EMIT;
            ST_STORE: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_fire) begin
                    if (r_last) n_state = ST_IDLE;
                    else if (w_hi == 4'hF && w_kk == 8'h33) n_state = ST_BCD;
                    else n_state = ST_STORE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Return stack: no reset, written on a call
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC && w_hi == 4'h2 && r_sp < SP_W'(STACK_DEPTH))
            r_stk[r_sp[SA_W-1:0]] <= w_pcf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
            r_pc   <= PC_RESET;
            r_i    <= 16'd0;
            r_sp   <= '0;
            r_font <= FONT_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_font <= i_cfg_data;
            if (w_take) begin
                r_op  <= s_axis_tdata[15:0];
                r_keys <= s_axis_tdata[31:16];
                r_rnd <= s_axis_tdata[39:32];
                r_dly <= s_axis_tdata[47:40];
            end
            case (r_state)
                ST_EXEC: begin
                    r_ev <= EV_DONE; r_addr <= 16'd0; r_data <= 8'd0; r_last <= 1'b1;
                    r_cnt <= 4'd0; r_rem <= w_vx; r_dig <= 4'd0;
                    r_pc <= w_pcf;
                    case (w_hi)
                        4'h0: begin
                            if (r_op == 16'h00E0) r_ev <= EV_CLEAR;
                            else if (r_op == 16'h00EE) begin
                                if (r_sp == '0) r_ev <= EV_UNDER;
                                else begin
                                    r_sp <= r_sp - 1'b1;
                                    r_pc <= r_stk[SA_W'(r_sp - 1'b1)];
                                end
                            end else r_ev <= EV_UNSUP;
                        end
                        4'h1: r_pc <= w_nnn;
                        4'h2: begin
                            if (r_sp >= SP_W'(STACK_DEPTH)) r_ev <= EV_OVER;
                            else begin r_sp <= r_sp + 1'b1; r_pc <= w_nnn; end
                        end
                        4'h3, 4'h5: if (w_alu.eq) r_pc <= w_pcf + 12'd2;
                        4'h4, 4'h9: if (!w_alu.eq) r_pc <= w_pcf + 12'd2;
                        4'h6: r_v[w_x] <= w_kk;
                        4'h7: begin
                            r_v[w_x] <= w_alu.res;
                            if (!(w_n == 4'h1 && w_vx == 8'hFF) && w_x != 4'hF)
                                r_v[15] <= {7'd0, w_alu.flag};
                        end
                        4'h8: begin
                            case (w_n)
                                4'h0, 4'h1, 4'h2, 4'h3: r_v[w_x] <= w_alu.res;
                                4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                                    r_v[15] <= {7'd0, w_alu.flag};
                                    r_v[w_x] <= w_alu.res;
                                end
                                default: r_ev <= EV_UNSUP;
                            endcase
                        end
                        4'hA: r_i <= {4'd0, w_nnn};
                        4'hB: r_pc <= w_nnn + {4'd0, r_v[0]};
                        4'hC: r_v[w_x] <= w_alu.res;
                        4'hD: r_ev <= EV_UNSUP;
                        4'hE: begin
                            if (w_kk == 8'h9E) begin
                                if (r_keys[w_vx[3:0]] && w_vx[7:4] == 4'd0)
                                    r_pc <= w_pcf + 12'd2;
                            end else if (w_kk == 8'hA1) begin
                                if (!(r_keys[w_vx[3:0]] && w_vx[7:4] == 4'd0))
                                    r_pc <= w_pcf + 12'd2;
                            end else r_ev <= EV_UNSUP;
                        end
                        default: begin
                            case (w_kk)
                                8'h07: r_v[w_x] <= r_dly;
                                8'h0A: begin r_ev <= EV_WAITKEY; r_data <= {4'd0, w_x}; end
                                8'h15: begin r_ev <= EV_SETDLY; r_data <= w_vx; end
                                8'h18: begin r_ev <= EV_SETSND; r_data <= w_vx; end
                                8'h1E: r_i <= r_i + {8'd0, w_vx};
                                8'h29: r_i <= {4'd0, r_font} + {6'd0, w_vx, 2'b00}
                                              + {8'd0, w_vx};
                                8'h33: r_last <= 1'b0;
                                8'h55: begin
                                    r_ev <= EV_MEMWRITE; r_addr <= r_i;
                                    r_data <= r_v[0]; r_last <= (w_x == 4'd0);
                                end
                                default: r_ev <= EV_UNSUP;
                            endcase
                        end
                    endcase
                end
                ST_BCD: begin
                    // one subtract-and-compare per cycle
                    if (w_alu.flag) begin
                        r_rem <= w_alu.res;
                        r_dig <= r_dig + 4'd1;
                    end else begin
                        r_ev <= EV_MEMWRITE;
                        r_addr <= r_i + {12'd0, r_cnt};
                        r_data <= (r_cnt == 4'd2) ? r_rem : {4'd0, r_dig};
                        r_last <= (r_cnt == 4'd2);
                        r_dig <= 4'd0;
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                ST_STORE: begin
                    r_ev   <= EV_MEMWRITE;
                    r_addr <= r_i + {12'd0, r_cnt + 4'd1};
                    r_data <= r_v[r_cnt + 4'd1];
                    r_last <= ((r_cnt + 4'd1) == w_x);
                    r_cnt  <= r_cnt + 4'd1;
                end
                default: ;
            endcase
        end
    end

    // One result per emit visit, the last one returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("last result did not return to idle");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted request while busy");
    a_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack level beyond depth");
endmodule

### test/tb_chip8_instruction_executor_unit.sv
// ============================================================================
// tb_chip8_instruction_executor_unit
// Self-checking bench for the CHIP-8 instruction executor: a cycle driver and
// a monitor around the block, a behavioral copy of the machine that predicts
// every emitted event, directed corner instructions and random programs.
// ============================================================================
`timescale 1ns / 1ps

module tb_chip8_instruction_executor_unit;
    import c8ie_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int WATCHDOG    = 20000;

    typedef struct packed {
        logic [7:0]  delay_now;
        logic [7:0]  random_byte;
        logic [15:0] key_mask;
        logic [15:0] opcode_word;
    } t_instr;

    // packed to match {m_axis_tdata, m_axis_tlast}
    typedef struct packed {
        logic [11:0] pc_now;
        logic [7:0]  out_data;
        logic [15:0] mem_addr;
        logic [3:0]  event_res;
        logic        last_of_run;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // opcode, key_mask, random_byte, delay_now
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // event_res, mem_addr, out_data, pc_now
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [11:0] i_cfg_data;

    chip8_instruction_executor_unit #(.STACK_DEPTH(STACK_DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    // Shadow machine state
    logic [7:0]  v_regs [16];
    logic [11:0] pc_shadow;
    logic [15:0] idx_shadow;
    logic [11:0] ret_stack [STACK_DEPTH];
    int          sp_shadow;
    logic [11:0] font_shadow;

    t_instr  instr_q[$];
    t_result event_q[$];
    int      errors;
    int      n_results;
    int      n_instr;
    int      quiet_cycles;
    bit      no_idle;
    int      src_idle, snk_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_event(ref t_result evs[$], input t_event ev,
                                       input logic [15:0] addr, input logic [7:0] data);
        t_result r;
        r = '0;
        r.event_res = ev;
        r.mem_addr  = addr;
        r.out_data  = data;
        evs.push_back(r);
    endfunction

    function automatic bit key_pressed(logic [15:0] keys, logic [7:0] k);
        return (k <= 8'd15) ? keys[k[3:0]] : 1'b0;
    endfunction

    // Execute one instruction on the shadow machine, queue its events
    task automatic execute_instr(input t_instr it);
        logic [3:0]  op, x, y, n;
        logic [7:0]  kk, vx, vy;
        logic [11:0] nnn;
        logic [8:0]  sum;
        t_result     evs[$];
        op  = it.opcode_word[15:12];
        x   = it.opcode_word[11:8];
        y   = it.opcode_word[7:4];
        n   = it.opcode_word[3:0];
        kk  = it.opcode_word[7:0];
        nnn = it.opcode_word[11:0];
        vx  = v_regs[x];
        vy  = v_regs[y];
        pc_shadow = pc_shadow + 12'd2;
        case (op)
            4'h0: begin
                if (it.opcode_word == 16'h00E0) begin
                    push_event(evs, EV_CLEAR, 0, 0);
                end else if (it.opcode_word == 16'h00EE) begin
                    if (sp_shadow == 0) begin
                        push_event(evs, EV_UNDER, 0, 0);
                    end else begin
                        sp_shadow--;
                        pc_shadow = ret_stack[sp_shadow];
                    end
                end else begin
                    push_event(evs, EV_UNSUP, 0, 0);
                end
            end
            4'h1: pc_shadow = nnn;
            4'h2: begin
                if (sp_shadow >= STACK_DEPTH) begin
                    push_event(evs, EV_OVER, 0, 0);
                end else begin
                    ret_stack[sp_shadow] = pc_shadow;
                    sp_shadow++;
                    pc_shadow = nnn;
                end
            end
            4'h3: if (vx == kk) pc_shadow += 12'd2;
            4'h4: if (vx != kk) pc_shadow += 12'd2;
            4'h5: if (vx == vy) pc_shadow += 12'd2;
            4'h6: v_regs[x] = kk;
            4'h7: begin
                sum = vx + kk;
                // odd carry rule: n of 1 with Vx saturated leaves VF alone
                if (!(n == 4'h1 && vx == 8'hFF)) v_regs[15] = {7'd0, sum[8]};
                v_regs[x] = sum[7:0];
            end
            4'h8: begin
                case (n)
                    4'h0: v_regs[x] = vy;
                    4'h1: v_regs[x] = vx | vy;
                    4'h2: v_regs[x] = vx & vy;
                    4'h3: v_regs[x] = vx ^ vy;
                    4'h4: begin
                        sum = vx + vy;
                        v_regs[15] = {7'd0, sum[8]};
                        v_regs[x]  = sum[7:0];
                    end
                    4'h5: begin
                        v_regs[15] = (vx < vy) ? 8'd0 : 8'd1;
                        v_regs[x]  = vx - vy;
                    end
                    4'h6: begin
                        v_regs[15] = {7'd0, vx[0]};
                        v_regs[x]  = vx >> 1;
                    end
                    4'h7: begin
                        v_regs[15] = (vy < vx) ? 8'd0 : 8'd1;
                        v_regs[x]  = vy - vx;
                    end
                    4'hE: begin
                        v_regs[15] = {7'd0, vx[7]};
                        v_regs[x]  = vx << 1;
                    end
                    default: push_event(evs, EV_UNSUP, 0, 0);
                endcase
            end
            4'h9: if (vx != vy) pc_shadow += 12'd2;
            4'hA: idx_shadow = {4'd0, nnn};
            4'hB: pc_shadow = nnn + {4'd0, v_regs[0]};
            4'hC: v_regs[x] = kk & it.random_byte;
            4'hD: push_event(evs, EV_UNSUP, 0, 0);
            4'hE: begin
                if (kk == 8'h9E) begin
                    if (key_pressed(it.key_mask, vx)) pc_shadow += 12'd2;
                end else if (kk == 8'hA1) begin
                    if (!key_pressed(it.key_mask, vx)) pc_shadow += 12'd2;
                end else begin
                    push_event(evs, EV_UNSUP, 0, 0);
                end
            end
            default: begin
                case (kk)
                    8'h07: v_regs[x] = it.delay_now;
                    8'h0A: push_event(evs, EV_WAITKEY, 0, {4'd0, x});
                    8'h15: push_event(evs, EV_SETDLY, 0, vx);
                    8'h18: push_event(evs, EV_SETSND, 0, vx);
                    8'h1E: idx_shadow = idx_shadow + vx;
                    8'h29: idx_shadow = {4'd0, font_shadow} + 16'(5 * vx);
                    8'h33: begin
                        push_event(evs, EV_MEMWRITE, idx_shadow, 8'(vx / 100));
                        push_event(evs, EV_MEMWRITE, idx_shadow + 16'd1,
                                   8'((vx / 10) % 10));
                        push_event(evs, EV_MEMWRITE, idx_shadow + 16'd2, 8'(vx % 10));
                    end
                    8'h55: begin
                        for (int i = 0; i <= x; i++)
                            push_event(evs, EV_MEMWRITE, idx_shadow + 16'(i), v_regs[i]);
                    end
                    default: push_event(evs, EV_UNSUP, 0, 0);
                endcase
            end
        endcase
        if (evs.size() == 0) push_event(evs, EV_DONE, 0, 0);
        foreach (evs[i]) begin
            evs[i].pc_now      = pc_shadow;
            evs[i].last_of_run = (i == evs.size() - 1);
            event_q.push_back(evs[i]);
        end
    endtask

    function automatic t_instr make_instr(logic [15:0] opw);
        t_instr it;
        it.opcode_word = opw;
        it.key_mask    = 16'($urandom);
        it.random_byte = 8'($urandom);
        it.delay_now   = 8'($urandom);
        return it;
    endfunction

    // Random opcode: mostly legal, with register content kept interesting
    function automatic logic [15:0] random_opcode();
        logic [15:0] w;
        int sel;
        sel = $urandom_range(0, 99);
        w   = 16'($urandom);
        if (sel < 8)       w = 16'h6000 | (w & 16'h0FFF);
        else if (sel < 14) w = 16'h7000 | (w & 16'h0FFF);
        else if (sel < 30) w = 16'h8000 | (w & 16'h0FF0) | 16'($urandom_range(0, 7));
        else if (sel < 34) w = 16'h800E | (w & 16'h0FF0);
        else if (sel < 40) w = 16'h2000 | (w & 16'h0FFF);
        else if (sel < 46) w = 16'h00EE;
        else if (sel < 52) w = {4'hF, w[11:8], 8'h55};
        else if (sel < 56) w = {4'hF, w[11:8], 8'h33};
        else if (sel < 62) w = {4'hE, w[11:8], ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
        else if (sel < 72) begin
            case ($urandom_range(0, 6))
                0: w[7:0] = 8'h07;
                1: w[7:0] = 8'h0A;
                2: w[7:0] = 8'h15;
                3: w[7:0] = 8'h18;
                4: w[7:0] = 8'h1E;
                5: w[7:0] = 8'h29;
                default: w[7:0] = 8'h65;
            endcase
            w[15:12] = 4'hF;
        end
        // the rest: any word at all
        return w;
    endfunction

    // Driver: feed queued requests, idling in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_idle      <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the request
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                execute_instr(instr_q.pop_front());
                n_instr++;
            end
            if (src_idle > 0) begin
                src_idle      <= src_idle - 1;
                s_axis_tvalid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                src_idle      <= $urandom_range(1, 17) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (instr_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= instr_q[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted event with the oldest prediction
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_idle      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata, m_axis_tlast};
                n_results++;
                if (event_q.size() == 0) begin
                    $error("unexpected event %0d", got.event_res);
                    errors++;
                end else begin
                    want = event_q.pop_front();
                    if (got.event_res !== want.event_res) begin
                        $error("event_res exp %0d got %0d", want.event_res, got.event_res);
                        errors++;
                    end
                    if (got.mem_addr !== want.mem_addr) begin
                        $error("mem_addr exp %h got %h", want.mem_addr, got.mem_addr);
                        errors++;
                    end
                    if (got.out_data !== want.out_data) begin
                        $error("out_data exp %h got %h", want.out_data, got.out_data);
                        errors++;
                    end
                    if (got.pc_now !== want.pc_now) begin
                        $error("pc_now exp %h got %h", want.pc_now, got.pc_now);
                        errors++;
                    end
                    if (got.last_of_run !== want.last_of_run) begin
                        $error("last_of_run exp %b got %b", want.last_of_run,
                               got.last_of_run);
                        errors++;
                    end
                end
            end
            if (snk_idle > 0) begin
                snk_idle      <= snk_idle - 1;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                snk_idle      <= $urandom_range(1, 17) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which no handshake completes
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Block until everything queued is executed and all events are back
    task automatic drain();
        while (instr_q.size() > 0 || s_axis_tvalid || event_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_font(logic [11:0] base);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= base;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        font_shadow = base;
    endtask

    initial begin
        logic [15:0] directed [$];
        logic [11:0] bases [4];
        errors = 0; n_results = 0; n_instr = 0; no_idle = 0;
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        foreach (v_regs[i]) v_regs[i] = '0;
        foreach (ret_stack[i]) ret_stack[i] = '0;
        pc_shadow = PC_RESET; idx_shadow = '0; sp_shadow = 0; font_shadow = FONT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-stack return, carry rule, ALU flags, stores, unknowns
        directed = '{16'h00EE, 16'h00E0, 16'h0123, 16'h60FF, 16'h7001, 16'h7F01,
                     16'h7002, 16'h61FF, 16'h8F14, 16'h8015, 16'h8F17, 16'h810E,
                     16'h8F16, 16'h8128, 16'h5121, 16'h9011, 16'h3000, 16'h4FFF,
                     16'hE09E, 16'hE1A1, 16'hA0FE, 16'hFF55, 16'hF133, 16'hF029,
                     16'hD123};
        foreach (directed[i]) instr_q.push_back(make_instr(directed[i]));
        instr_q.push_back(make_instr(16'hFFFF));
        instr_q.push_back(make_instr(16'hBFFF));
        drain();

        // Fill the stack past its depth, then unwind past empty
        for (int i = 0; i <= STACK_DEPTH; i++)
            instr_q.push_back(make_instr(16'h2000 | 16'($urandom_range(0, 4095))));
        for (int i = 0; i <= STACK_DEPTH; i++) instr_q.push_back(make_instr(16'h00EE));
        drain();

        // Random phases under several font base settings
        bases = '{12'd0, 12'hFFF, 12'd80, 12'($urandom)};
        foreach (bases[p]) begin
            write_font(bases[p]);
            if (p == 3) no_idle = 1;
            repeat (35) instr_q.push_back(make_instr(random_opcode()));
            drain();
        end

        $display("ran %0d instructions, %0d events checked, 4 font bases, stack extremes",
                 n_instr, n_results);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
